@@ rtl/rid_pkg.sv @@
// Package for the radix integer to digits unit.
// Holds widths, radix bounds, the controller state type and the digit character map.
// No dependencies.
package rid_pkg;

  localparam int IN_VALUE_W  = 64;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 6;

  localparam int VALUE_WIDTH = 64;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int DEPTH       = VALUE_WIDTH;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int SP_W        = $clog2(DEPTH + 1);

  localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(36);

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = CHAR_W'(97);
  localparam logic [DIGIT_W-1:0] DECIMAL_TOP = DIGIT_W'(10);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_SHOW
  } ctrl_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < MIN_RADIX) begin
      res = MIN_RADIX;
    end else if (r > MAX_RADIX) begin
      res = MAX_RADIX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DECIMAL_TOP) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_LOWER_A + CHAR_W'(d - DECIMAL_TOP);
    end
    return res;
  endfunction

endpackage

@@ rtl/rid_in_if.sv @@
// Input channel of the radix integer to digits unit: value and radix.
// Depends on rid_pkg.
interface rid_in_if;
  logic                         valid;
  logic                         ready;
  logic [rid_pkg::IN_VALUE_W-1:0] value;
  logic [rid_pkg::RADIX_W-1:0]  radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

@@ rtl/rid_out_if.sv @@
// Result channel of the radix integer to digits unit: one digit character per transfer.
// Depends on rid_pkg.
interface rid_out_if;
  logic                      valid;
  logic                      ready;
  logic [rid_pkg::CHAR_W-1:0] digit_char;
  logic                      last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

@@ rtl/radix_integer_to_digits_unit.sv @@
// Top level of the radix integer to digits unit: controller, divider and digit stack.
// Depends on rid_pkg, rid_in_if, rid_out_if, rid_divider and rid_digit_stack.
//
// Usage: in_ch carries a value (low VALUE_WIDTH bits used, read as unsigned) and a
// radix; a radix below 2 is taken as 2, above 36 as 36. out_ch returns the digits
// as lowercase ASCII, most significant first, without leading zeros; a zero value
// gives the single digit '0'. last_digit marks the final transfer of a run.
// The block takes one item at a time: in_ch.ready is high only while idle.
// Each digit comes from the bit-serial divider, which shifts one quotient bit per
// cycle and restarts on the quotient until it is zero; the first result appears
// after the last division and a stack read.
// Emission then handles each digit as a stack read, then a transfer.
// A stalled receiver holds the current digit on out_ch until it is taken; the
// block waits and loses nothing. Reset empties the stack and returns to idle;
// no clearing pass is needed.
module radix_integer_to_digits_unit (
  input  logic     clk,
  input  logic     rst_n,
  rid_in_if.sink   in_ch,
  rid_out_if.source out_ch
);

  rid_pkg::ctrl_state_t state_r, state_nxt;

  logic [rid_pkg::RADIX_W-1:0]     radix_r, radix_nxt;
  logic                            in_xfer;
  logic                            out_xfer;
  logic                            div_start;
  logic [rid_pkg::VALUE_WIDTH-1:0] dividend;
  rid_pkg::div_stat_t              div_stat;
  logic [rid_pkg::VALUE_WIDTH-1:0] quotient;
  logic [rid_pkg::DIGIT_W-1:0]     remainder;
  logic                            quot_zero;
  logic                            push;
  logic                            pop;
  logic [rid_pkg::DIGIT_W-1:0]     pop_digit;
  logic                            empty;

  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;
  assign quot_zero = (quotient == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rid_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = rid_pkg::S_DIV;
      end
      rid_pkg::S_DIV: begin
        if (div_stat.done && quot_zero) state_nxt = rid_pkg::S_READ;
      end
      rid_pkg::S_READ: begin
        state_nxt = rid_pkg::S_SHOW;
      end
      rid_pkg::S_SHOW: begin
        if (out_xfer) state_nxt = empty ? rid_pkg::S_IDLE : rid_pkg::S_READ;
      end
      default: state_nxt = rid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    div_start    = 1'b0;
    dividend     = quotient;
    push         = 1'b0;
    pop          = 1'b0;
    radix_nxt    = radix_r;
    unique case (state_r)
      rid_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        dividend    = in_ch.value[rid_pkg::VALUE_WIDTH-1:0];
        div_start   = in_xfer;
        if (in_xfer) radix_nxt = rid_pkg::clamp_radix(in_ch.radix);
      end
      rid_pkg::S_DIV: begin
        push      = div_stat.done;
        div_start = div_stat.done && !quot_zero;
      end
      rid_pkg::S_READ: begin
        pop = 1'b1;
      end
      rid_pkg::S_SHOW: begin
        out_ch.valid = 1'b1;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r <= radix_nxt;
  end

  assign out_ch.digit_char = rid_pkg::digit_char(pop_digit);
  assign out_ch.last_digit = empty;

  rid_divider u_divider (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (dividend),
    .radix     (radix_r),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  rid_digit_stack u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_digit (remainder),
    .pop        (pop),
    .pop_digit  (pop_digit),
    .empty      (empty)
  );

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == rid_pkg::S_DIV) && div_stat.busy)
    else $error("divider not started after input transfer");

  a_next_digit: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == rid_pkg::S_DIV) && div_stat.done && !quot_zero) |=> div_stat.busy)
    else $error("divider not restarted on non-zero quotient");

  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (remainder < radix_r))
    else $error("remainder not below radix");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_ch.last_digit) |=> (state_r == rid_pkg::S_IDLE))
    else $error("run not ended after last digit");

endmodule

@@ rtl/rid_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, remainder below the radix.
// Depends on rid_pkg.
module rid_divider (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [rid_pkg::VALUE_WIDTH-1:0]    dividend,
  input  logic [rid_pkg::RADIX_W-1:0]        radix,
  output rid_pkg::div_stat_t                 stat,
  output logic [rid_pkg::VALUE_WIDTH-1:0]    quotient,
  output logic [rid_pkg::DIGIT_W-1:0]        remainder
);

  localparam int W = rid_pkg::VALUE_WIDTH;

  logic [W-1:0]                q_r, q_nxt;
  logic [rid_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [rid_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [rid_pkg::DIGIT_W:0]   trial;
  logic [rid_pkg::DIGIT_W:0]   diff;
  logic                        ge;

  assign trial = {rem_r, q_r[W-1]};
  assign diff  = trial - {1'b0, radix};
  assign ge    = trial >= {1'b0, radix};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[W-2:0], ge};
      rem_nxt = ge ? diff[rid_pkg::DIGIT_W-1:0] : trial[rid_pkg::DIGIT_W-1:0];
      if (cnt_r == rid_pkg::CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

@@ rtl/rid_digit_stack.sv @@
// Digit stack: pushes remainders least significant first, pops them most significant first.
// Memory with registered read data. Depends on rid_pkg.
module rid_digit_stack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [rid_pkg::DIGIT_W-1:0] push_digit,
  input  logic                        pop,
  output logic [rid_pkg::DIGIT_W-1:0] pop_digit,
  output logic                        empty
);

  logic [rid_pkg::DIGIT_W-1:0] mem [rid_pkg::DEPTH];
  logic [rid_pkg::SP_W-1:0]    sp_r, sp_nxt;
  logic [rid_pkg::SP_W-1:0]    sp_m1;
  logic [rid_pkg::DIGIT_W-1:0] rd_r;

  assign sp_m1 = sp_r - 1'b1;

  always_comb begin
    sp_nxt = sp_r;
    if (push) begin
      sp_nxt = sp_r + 1'b1;
    end else if (pop) begin
      sp_nxt = sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[sp_r[rid_pkg::ADDR_W-1:0]] <= push_digit;
    end
    if (pop) begin
      rd_r <= mem[sp_m1[rid_pkg::ADDR_W-1:0]];
    end
  end

  assign pop_digit = rd_r;
  assign empty     = (sp_r == '0);

endmodule
